[sv/dedup_fifo_seek_point_cache_macros.svh]
// Assertion macros used by the seek point cache top level.
`ifndef DEDUP_FIFO_SEEK_POINT_CACHE_MACROS_SVH
`define DEDUP_FIFO_SEEK_POINT_CACHE_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define DFSPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("seek point cache: same-cycle check failed");
// Antecedent implies consequent in the next cycle.
`define DFSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("seek point cache: next-cycle check failed");
`else
`define DFSPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DFSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/dfspc_pkg.sv]
// Shared constants, codes and types of the seek point cache.
package dfspc_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int OFFSET_BITS   = 48;

    localparam int TIME_W     = 31;
    localparam int PT_TIME_W  = 32;
    localparam int PT_OFF_W   = 48;
    localparam int WINDOW_W   = 16;
    localparam int COUNT_OUT_W = 8;
    localparam int OFF_W      = (OFFSET_BITS < PT_OFF_W) ? OFFSET_BITS : PT_OFF_W;
    localparam int IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W    = TIME_W + OFF_W;
    localparam int ENTRIES_SAT = (TABLE_ENTRIES > 255) ? 255 : TABLE_ENTRIES;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(20);

    typedef logic [1:0] t_status;
    localparam t_status ST_IGNORED = 2'd0;
    localparam t_status ST_UPDATED = 2'd1;
    localparam t_status ST_ADDED   = 2'd2;
    localparam t_status ST_EVICTED = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic advance;
        logic commit_hit;
        logic commit_miss;
        logic commit_ign;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic ign;
        logic hit;
        logic miss;
        logic out_free;
    } t_stat;

    // Clamp the entry count to the width of the result field
    function automatic logic [COUNT_OUT_W-1:0] count_sat(input logic [CNT_W-1:0] c);
        logic [COUNT_OUT_W-1:0] r;
        if (c > CNT_W'(255)) begin
            r = COUNT_OUT_W'(255);
        end else begin
            r = COUNT_OUT_W'(c);
        end
        return r;
    endfunction

endpackage

[sv/dfspc_in_if.sv]
// Input channel of the seek point cache: one offered seek point per beat.
interface dfspc_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [dfspc_pkg::PT_TIME_W-1:0]     point_time_ms;
    logic        [dfspc_pkg::PT_OFF_W-1:0]      point_offset;

    modport source (output valid, output point_time_ms, output point_offset, input ready);
    modport sink   (input valid, input point_time_ms, input point_offset, output ready);
endinterface

[sv/dfspc_out_if.sv]
// Result channel of the seek point cache: one result per beat.
interface dfspc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             status;
    logic [dfspc_pkg::TIME_W-1:0]           echo_time_ms;
    logic [dfspc_pkg::PT_OFF_W-1:0]         echo_offset;
    logic [dfspc_pkg::COUNT_OUT_W-1:0]      entries_after;

    modport source (output valid, output status, output echo_time_ms, output echo_offset,
                    output entries_after, input ready);
    modport sink   (input valid, input status, input echo_time_ms, input echo_offset,
                    input entries_after, output ready);
endinterface

[sv/dfspc_ctrl.sv]
// Controller of the seek point cache: sequences accept, scan and commit.
module dfspc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  dfspc_pkg::t_stat i_stat,
    output logic             o_in_ready,
    output dfspc_pkg::t_cmd  o_cmd
);
    import dfspc_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    logic r_state;
    logic n_state;

    // Decide the next state and the datapath command
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_BUSY;
                end
            end
            S_BUSY: begin
                if (i_stat.ign || i_stat.hit || i_stat.miss) begin
                    // hold the decision until the result register is free
                    if (i_stat.out_free) begin
                        o_cmd.commit_ign  = i_stat.ign;
                        o_cmd.commit_hit  = i_stat.hit;
                        o_cmd.commit_miss = i_stat.miss;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/dfspc_dp.sv]
// Datapath of the seek point cache: entry memory, ring pointers, match logic, result register.
module dfspc_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  dfspc_pkg::t_cmd                       i_cmd,
    output dfspc_pkg::t_stat                      o_stat,
    input  logic                                  i_cfg_wr_en,
    input  logic [dfspc_pkg::WINDOW_W-1:0]        i_cfg_wr_data,
    input  logic signed [dfspc_pkg::PT_TIME_W-1:0] i_point_time_ms,
    input  logic [dfspc_pkg::PT_OFF_W-1:0]        i_point_offset,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic [1:0]                            o_status,
    output logic [dfspc_pkg::TIME_W-1:0]          o_echo_time_ms,
    output logic [dfspc_pkg::PT_OFF_W-1:0]        o_echo_offset,
    output logic [dfspc_pkg::COUNT_OUT_W-1:0]     o_entries_after
);
    import dfspc_pkg::*;

    // Entry memory, {time, offset} per slot
    logic [ENTRY_W-1:0] r_mem [TABLE_ENTRIES];

    logic [WINDOW_W-1:0] r_window;
    logic [IDX_W-1:0]    r_oldest;
    logic [CNT_W-1:0]    r_count;

    logic [TIME_W-1:0]   r_time;
    logic [OFF_W-1:0]    r_offset;
    logic                r_neg;

    logic [CNT_W-1:0]    r_rd_step;
    logic [IDX_W-1:0]    r_rd_slot;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_slot;
    logic [ENTRY_W-1:0]  r_rd_data;

    logic                r_out_vld;
    t_status             r_status;
    logic [TIME_W-1:0]   r_echo_time;
    logic [PT_OFF_W-1:0] r_echo_off;
    logic [COUNT_OUT_W-1:0] r_entries;

    logic [TIME_W-1:0]   s_time;
    logic [OFF_W-1:0]    s_off;
    logic [TIME_W-1:0]   d_ts;
    logic [TIME_W-1:0]   d_st;
    logic [TIME_W-1:0]   abs_d;
    logic                t_gt;
    logic                match;
    logic                rd_more;
    logic                full;
    logic                out_free;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == IDX_W'(TABLE_ENTRIES - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Compare the entry just read against the offered point
    always_comb begin
        s_time  = r_rd_data[OFF_W +: TIME_W];
        s_off   = r_rd_data[OFF_W-1:0];
        t_gt    = r_time > s_time;
        d_ts    = r_time - s_time;
        d_st    = s_time - r_time;
        abs_d   = t_gt ? d_ts : d_st;
        match   = (s_off == r_offset) || (abs_d <= TIME_W'(r_window));
        rd_more = r_rd_step < r_count;
        full    = r_count == CNT_W'(TABLE_ENTRIES);
        out_free = !r_out_vld || i_out_ready;
    end

    assign o_stat.ign      = r_neg;
    assign o_stat.hit      = !r_neg && r_cmp_vld && match;
    assign o_stat.miss     = !r_neg && !r_cmp_vld && !rd_more;
    assign o_stat.out_free = out_free;

    // Write on a newer hit, or append over the slot after the newest
    assign mem_we    = (i_cmd.commit_hit && t_gt) || i_cmd.commit_miss;
    assign mem_waddr = i_cmd.commit_hit ? r_cmp_slot : r_rd_slot;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= {r_time, r_offset};
        end
        if (i_cmd.advance && rd_more) begin
            r_rd_data <= r_mem[r_rd_slot];
        end
    end

    // Capture the beat and walk the ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_time    <= i_point_time_ms[TIME_W-1:0];
            r_offset  <= i_point_offset[OFF_W-1:0];
            r_neg     <= i_point_time_ms[PT_TIME_W-1];
            r_rd_step <= '0;
            r_rd_slot <= r_oldest;
        end else if (i_cmd.advance && rd_more) begin
            r_cmp_slot <= r_rd_slot;
            r_rd_step  <= r_rd_step + 1'b1;
            r_rd_slot  <= ring_inc(r_rd_slot);
        end
    end

    // Control state: window, ring head and count, compare valid, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= WINDOW_RESET;
            r_oldest  <= '0;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.advance) begin
                r_cmp_vld <= rd_more;
            end
            if (i_cmd.commit_miss) begin
                if (full) begin
                    r_oldest <= ring_inc(r_oldest);
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.commit_hit || i_cmd.commit_miss || i_cmd.commit_ign) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_ign) begin
            r_status    <= ST_IGNORED;
            r_echo_time <= '0;
            r_echo_off  <= '0;
            r_entries   <= '0;
        end else if (i_cmd.commit_hit || i_cmd.commit_miss) begin
            r_echo_time <= r_time;
            r_echo_off  <= PT_OFF_W'(r_offset);
            if (i_cmd.commit_hit) begin
                r_status  <= ST_UPDATED;
                r_entries <= count_sat(r_count);
            end else if (full) begin
                r_status  <= ST_EVICTED;
                r_entries <= count_sat(r_count);
            end else begin
                r_status  <= ST_ADDED;
                r_entries <= count_sat(r_count + 1'b1);
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_status;
    assign o_echo_time_ms  = r_echo_time;
    assign o_echo_offset   = r_echo_off;
    assign o_entries_after = r_entries;

endmodule

[sv/dedup_fifo_seek_point_cache.sv]
// Top level of the seek point cache with duplicate merging.
//
//  channel   dir  beat contents                               handshake
//  i_pt      in   point_time_ms, point_offset                 valid / ready
//  o_res     out  status, echo_time_ms, echo_offset,          valid / ready
//                 entries_after
//  i_cfg     in   match_window_ms                             i_cfg_wr_en, no wait
//
// One point is in work at a time. After the accept, the single-port entry
// memory is read one entry a cycle, oldest first, and each entry is compared
// in turn; the decision then waits for a free output register.
// A hit ends the scan early. The result sits in an output register while the
// next point is accepted and scanned; a point that finishes before it is taken
// holds in place. Reset clears the ring head and the count and sets the window to 20 ms;
// the entry memory needs no clearing.
module dedup_fifo_seek_point_cache (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [dfspc_pkg::WINDOW_W-1:0] i_cfg_wr_data,
    dfspc_in_if.sink                       i_pt,
    dfspc_out_if.source                    o_res
);
    import dfspc_pkg::*;

`include "dedup_fifo_seek_point_cache_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    // Sequence each point
    dfspc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .i_stat     (stat),
        .o_in_ready (i_pt.ready),
        .o_cmd      (cmd)
    );

    // Store, match and report
    dfspc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_point_time_ms (i_pt.point_time_ms),
        .i_point_offset  (i_pt.point_offset),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_status        (o_res.status),
        .o_echo_time_ms  (o_res.echo_time_ms),
        .o_echo_offset   (o_res.echo_offset),
        .o_entries_after (o_res.entries_after)
    );

    // Checks
    `DFSPC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_pt.valid && i_pt.ready, !i_pt.ready)
    `DFSPC_ASSERT_IMP(a_commit_needs_room, i_clk, i_rst_n, cmd.commit_hit || cmd.commit_miss || cmd.commit_ign, stat.out_free)
    `DFSPC_ASSERT_IMP(a_evict_when_full, i_clk, i_rst_n, o_res.valid && (o_res.status == ST_EVICTED), o_res.entries_after == COUNT_OUT_W'(ENTRIES_SAT))

endmodule

[verif/dedup_fifo_seek_point_cache_test.sv]
// Self-checking testbench for the seek point cache with duplicate merging.
`timescale 1ns / 1ps

module dedup_fifo_seek_point_cache_test;
    import dfspc_pkg::*;

    localparam int     SLOW_HOLD    = 400;
    localparam int     DRAIN_CYCLES = TABLE_ENTRIES + 12;
    localparam int     HISTORY_MAX  = 160;
    localparam longint TIME_TOP     = 64'h7FFF_FFFF;

    typedef struct packed {
        logic signed [PT_TIME_W-1:0] pt_time;
        logic [PT_OFF_W-1:0]         pt_offset;
    } t_seek_point;

    typedef struct packed {
        t_status                status;
        logic [TIME_W-1:0]      echo_time;
        logic [PT_OFF_W-1:0]    echo_offset;
        logic [COUNT_OUT_W-1:0] entries;
    } t_seek_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [WINDOW_W-1:0] i_cfg_wr_data;

    dfspc_in_if  pt_if ();
    dfspc_out_if res_if ();

    dedup_fifo_seek_point_cache uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pt          (pt_if),
        .o_res         (res_if)
    );

    // Shadow copy of the point table and the window register
    logic [TIME_W-1:0]   cache_time   [TABLE_ENTRIES];
    logic [PT_OFF_W-1:0] cache_offset [TABLE_ENTRIES];
    int unsigned         cache_head  = 0;
    int unsigned         cache_count = 0;
    logic [WINDOW_W-1:0] window_ms   = WINDOW_RESET;

    t_seek_point  pending_points[$];
    t_seek_point  recent_points[$];
    t_seek_result predicted_results[$];
    t_seek_result oldest_due;
    t_seek_point  next_offer;

    int unsigned mismatch_count = 0;
    int unsigned send_idle_max  = 18;
    int unsigned recv_idle_max  = 18;
    int unsigned hold_seq       = 0;
    int unsigned hold_seen      = 0;
    int          hold_left      = 0;
    int          recv_wait      = 0;
    int          gap_left       = 0;
    logic        offer_held;

    // Merge one offered point into the shadow table and return its result
    function automatic t_seek_result merge_point(input t_seek_point p);
        t_seek_result      r;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] d;
        int unsigned       slot;
        int unsigned       i;
        bit                hit;
        r = '0;
        if (p.pt_time[PT_TIME_W-1]) begin
            return r;
        end
        t = p.pt_time[TIME_W-1:0];
        hit = 1'b0;
        i = 0;
        // Scan oldest first; the first close or same-offset entry wins
        while (!hit && i < cache_count) begin
            slot = (cache_head + i) % TABLE_ENTRIES;
            s = cache_time[slot];
            d = (s > t) ? s - t : t - s;
            if (cache_offset[slot] == p.pt_offset || d <= TIME_W'(window_ms)) begin
                hit = 1'b1;
                if (t > s) begin
                    cache_time[slot]   = t;
                    cache_offset[slot] = p.pt_offset;
                end
            end
            i++;
        end
        if (hit) begin
            r.status = ST_UPDATED;
        end else if (cache_count >= TABLE_ENTRIES) begin
            // Full: overwrite the oldest and advance the head
            cache_time[cache_head]   = t;
            cache_offset[cache_head] = p.pt_offset;
            cache_head = (cache_head + 1) % TABLE_ENTRIES;
            r.status = ST_EVICTED;
        end else begin
            slot = (cache_head + cache_count) % TABLE_ENTRIES;
            cache_time[slot]   = t;
            cache_offset[slot] = p.pt_offset;
            cache_count++;
            r.status = ST_ADDED;
        end
        r.echo_time   = t;
        r.echo_offset = p.pt_offset;
        r.entries     = (cache_count > 255) ? COUNT_OUT_W'(255) : COUNT_OUT_W'(cache_count);
        return r;
    endfunction

    // Draw a random point: often near earlier points, else fresh, sometimes negative
    function automatic t_seek_point draw_point(input int unsigned span);
        t_seek_point p;
        t_seek_point h;
        longint      t;
        int unsigned pick;
        int unsigned reach;
        pick = $urandom_range(0, 99);
        p.pt_offset = {16'($urandom()), 32'($urandom())};
        t = longint'($urandom_range(0, span));
        if (pick < 8) begin
            p.pt_time = {1'b1, 31'($urandom())};
            return p;
        end
        if (recent_points.size() != 0 && pick < 50) begin
            h = recent_points[$urandom_range(0, recent_points.size() - 1)];
            reach = (pick < 30) ? 40 : int'(window_ms) + 3;
            t = longint'(h.pt_time) + longint'($urandom_range(0, 2 * reach)) - longint'(reach);
            // Reuse the offset too, so offset matches arrive with times up to 40 ms away
            if (pick < 30) begin
                p.pt_offset = h.pt_offset;
            end
        end else if (pick >= 80) begin
            p.pt_offset = PT_OFF_W'($urandom_range(0, 255));
        end
        if (t < 0) begin
            t = 0;
        end else if (t > TIME_TOP) begin
            t = TIME_TOP;
        end
        p.pt_time = PT_TIME_W'(t);
        recent_points = {recent_points, p};
        if (recent_points.size() > HISTORY_MAX) begin
            void'(recent_points.pop_front());
        end
        return p;
    endfunction

    function automatic void queue_point(input logic [PT_TIME_W-1:0] t,
                                        input logic [PT_OFF_W-1:0] off);
        t_seek_point p;
        p.pt_time   = t;
        p.pt_offset = off;
        pending_points = {pending_points, p};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 60) begin
            $display("mismatch on %s at %0t: got %0h, expected %0h", what, $time, got, want);
        end
    endtask

    // Wait until every queued point has been taken and every result has come back
    task automatic drain();
        @(negedge i_clk);
        while (pending_points.size() != 0 || pt_if.valid || predicted_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_window(input logic [WINDOW_W-1:0] w);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        window_ms = w;
    endtask

    task automatic run_phase(input logic [WINDOW_W-1:0] w, input int n,
                             input int unsigned span, input int unsigned send_max,
                             input int unsigned recv_max, input bit squeeze,
                             input bit pause_mid);
        int k;
        drain();
        write_window(w);
        send_idle_max = send_max;
        recv_idle_max = recv_max;
        if (squeeze) begin
            hold_seq++;
        end
        for (k = 0; k < n; k++) begin
            if (pause_mid && k == n / 2) begin
                drain();
            end
            pending_points = {pending_points, draw_point(span)};
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Driver: offer queued points, predict each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            offer_held = pt_if.valid;
            if (pt_if.valid && pt_if.ready) begin
                predicted_results = {predicted_results,
                    merge_point(t_seek_point'({pt_if.point_time_ms, pt_if.point_offset}))};
                offer_held = 1'b0;
                gap_left = $urandom_range(0, send_idle_max);
            end
            if (!offer_held) begin
                if (gap_left != 0) begin
                    gap_left--;
                    pt_if.valid <= 1'b0;
                end else if (pending_points.size() != 0) begin
                    next_offer = pending_points.pop_front();
                    pt_if.valid         <= 1'b1;
                    pt_if.point_time_ms <= next_offer.pt_time;
                    pt_if.point_offset  <= next_offer.pt_offset;
                end else begin
                    pt_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat, stall the output at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_seen = hold_seq;
            hold_left = 0;
            recv_wait = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("beat with no point outstanding", 64'(res_if.status),
                                    64'(0));
                end else begin
                    oldest_due = predicted_results.pop_front();
                    if (res_if.status !== oldest_due.status) begin
                        report_mismatch("status", 64'(res_if.status),
                                        64'(oldest_due.status));
                    end
                    if (res_if.echo_time_ms !== oldest_due.echo_time) begin
                        report_mismatch("echo_time_ms", 64'(res_if.echo_time_ms),
                                        64'(oldest_due.echo_time));
                    end
                    if (res_if.echo_offset !== oldest_due.echo_offset) begin
                        report_mismatch("echo_offset", 64'(res_if.echo_offset),
                                        64'(oldest_due.echo_offset));
                    end
                    if (res_if.entries_after !== oldest_due.entries) begin
                        report_mismatch("entries_after", 64'(res_if.entries_after),
                                        64'(oldest_due.entries));
                    end
                end
                recv_wait = $urandom_range(0, recv_idle_max);
            end
            // Long hold-off first, then the per-beat stall
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = SLOW_HOLD;
                res_if.ready <= 1'b0;
            end else if (recv_wait != 0) begin
                recv_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_wr_data       = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window of 20 ms: empty table, ignores, window edges
        queue_point(32'd0, 48'd0);
        queue_point(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_point(32'h8000_0000, 48'h5555_5555_5555);
        queue_point(32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_point(32'd1000, 48'h1234);
        queue_point(32'd1020, 48'hABCD);
        queue_point(32'd1041, 48'h9999);
        // Same offset with an older time: hit, entry kept
        queue_point(32'd500, 48'hABCD);
        // Equal time: hit, no overwrite
        queue_point(32'd1020, 48'h77);
        // Close to the oldest and same offset as a newer one: oldest wins
        queue_point(32'd5, 48'hFFFF_FFFF_FFFF);
        queue_point(32'h7FFF_FFEC, 48'h1);
        drain();

        // Zero window: only equal times or equal offsets merge
        write_window('0);
        queue_point(32'd1020, 48'h42);
        queue_point(32'd1021, 48'h43);
        queue_point(32'h2AAA_AAAA, 48'hAAAA_AAAA_AAAA);
        drain();

        // Widest window
        write_window({WINDOW_W{1'b1}});
        queue_point(32'd66556, 48'h500);
        queue_point(32'd200000, 48'h501);
        queue_point(32'd134465, 48'h502);
        queue_point(32'h7FFF_0000, 48'h8000_0000_0000);

        // Random phases over several window settings
        run_phase(WINDOW_W'(20), 260, 32'h7FFF_FFFF, 18, 18, 1'b1, 1'b0);
        run_phase('0, 255, 4000, 0, 0, 1'b0, 1'b0);
        run_phase({WINDOW_W{1'b1}}, 255, 32'h7FFF_FFFF, 18, 18, 1'b0, 1'b1);
        run_phase(WINDOW_W'($urandom_range(0, 65535)), 255, 5000000, 18, 0, 1'b0, 1'b0);
        run_phase(WINDOW_W'(1), 255, 2000, 0, 18, 1'b1, 1'b0);
        run_phase(WINDOW_W'(300), 255, 32'h7FFF_FFFF, 18, 18, 1'b0, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #12_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
